// ===== rtl/nuft_pkg.sv =====
package nuft_pkg;

    // Parser phases of the source unit stream
    typedef enum logic [2:0] {
        PH_TYPE     = 3'd0,
        PH_T0_COUNT = 3'd1,
        PH_T0_HI    = 3'd2,
        PH_T0_LO    = 3'd3,
        PH_T1_COUNT = 3'd4,
        PH_T1_EMPTY = 3'd5,
        PH_T1_NUM   = 3'd6,
        PH_T1_JUNK  = 3'd7
    } t_phase;

    localparam int LIT_N = 3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;

    localparam logic [7:0] TYPE_BIN = 8'd0;
    localparam logic [7:0] TYPE_TXT = 8'd1;

    // One input byte's worth of output work: literal bytes first, then an
    // optional decimal number (digit position counts down to 0), then an
    // optional comma. A command with nothing to write carries a status.
    typedef struct packed {
        logic [LIT_N-1:0][7:0] lits;
        logic [1:0]            lit_cnt;
        logic                  num_en;
        logic [15:0]           num_val;
        logic [2:0]            num_pos;
        logic                  comma;
        logic [1:0]            st;
    } t_cmd;

    // Position of the leading decimal digit, 0 for units
    function automatic logic [2:0] lead_pos(input logic [15:0] v);
        logic [2:0] p;
        begin
            if (v >= 16'd10000)     p = 3'd4;
            else if (v >= 16'd1000) p = 3'd3;
            else if (v >= 16'd100)  p = 3'd2;
            else if (v >= 16'd10)   p = 3'd1;
            else                    p = 3'd0;
            return p;
        end
    endfunction

    // Split v (below 10*p) into its leading digit and the remainder
    function automatic logic [19:0] dec_split(input logic [15:0] v, input int unsigned p);
        logic [3:0] d;
        begin
            d = 4'd0;
            for (int unsigned k = 1; k < 10; k++) begin
                if (32'(v) >= k * p) d = 4'(k);
            end
            return {d, 16'(32'(v) - 32'(d) * p)};
        end
    endfunction

    function automatic logic [19:0] dec_step(input logic [15:0] v, input logic [2:0] pos);
        logic [19:0] r;
        begin
            case (pos)
                3'd0:    r = dec_split(v, 1);
                3'd1:    r = dec_split(v, 10);
                3'd2:    r = dec_split(v, 100);
                3'd3:    r = dec_split(v, 1000);
                3'd4:    r = dec_split(v, 10000);
                default: r = dec_split(v, 1);
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/nuft_front.sv =====
module nuft_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_space,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [1:0]        i_mode,
    output logic              o_push,
    output nuft_pkg::t_cmd    o_cmd
);
    import nuft_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_left, n_left;
    logic [9:0]  r_cnt, n_cnt;
    logic [1:0]  r_digits, n_digits;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_acc, n_acc;
    logic        r_err, n_err;
    logic        r_stop, n_stop;

    t_cmd        cmd;
    logic [1:0]  lc;
    logic        do_type;
    logic        accept;
    logic        conv0, conv1;
    logic        is_digit;
    logic [3:0]  dig;
    logic [15:0] word;

    assign accept   = i_valid & i_space;
    assign conv0    = i_mode[0];
    assign conv1    = i_mode[1];
    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign dig      = i_byte[3:0];
    assign word     = {r_hi, i_byte};

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_digits = r_digits;
        n_hi     = r_hi;
        n_acc    = r_acc;
        n_err    = r_err;
        n_stop   = r_stop;
        cmd      = '0;
        lc       = 2'd0;
        do_type  = 1'b0;

        if (r_err) begin
            // drop everything up to the end of the stream
            if (i_last) begin
                n_err   = 1'b0;
                n_phase = PH_TYPE;
            end
        end else begin
            case (r_phase)
                PH_TYPE: begin
                    do_type = 1'b1;
                end
                PH_T0_COUNT: begin
                    n_left = i_byte;
                    if (conv0) begin
                        cmd.num_en  = 1'b1;
                        cmd.num_val = {8'd0, i_byte};
                        cmd.num_pos = 3'd2;
                    end else begin
                        cmd.lits[lc] = i_byte;
                        lc = lc + 2'd1;
                    end
                    n_phase = (i_byte != 8'd0) ? PH_T0_HI : PH_TYPE;
                end
                PH_T0_HI: begin
                    n_hi    = i_byte;
                    n_phase = PH_T0_LO;
                end
                PH_T0_LO: begin
                    if (conv0) begin
                        cmd.num_en  = 1'b1;
                        cmd.num_val = word;
                        cmd.num_pos = lead_pos(word);
                        cmd.comma   = (r_left > 8'd1);
                    end else begin
                        cmd.lits[lc] = r_hi;
                        lc = lc + 2'd1;
                        cmd.lits[lc] = i_byte;
                        lc = lc + 2'd1;
                    end
                    if (r_left != 8'd0) n_left = r_left - 8'd1;
                    n_phase = (n_left != 8'd0) ? PH_T0_HI : PH_TYPE;
                end
                PH_T1_COUNT: begin
                    if (!conv1) begin
                        cmd.lits[lc] = i_byte;
                        lc = lc + 2'd1;
                    end
                    if (is_digit && !r_stop) begin
                        n_cnt = 10'(r_cnt * 10'd10 + {6'd0, dig});
                    end else begin
                        n_stop = 1'b1;
                    end
                    if (r_digits >= 2'd2) begin
                        n_left = n_cnt[7:0];
                        if (conv1) begin
                            cmd.lits[lc] = n_cnt[7:0];
                            lc = lc + 2'd1;
                        end
                        n_digits = 2'd0;
                        n_acc    = 16'd0;
                        n_phase  = PH_T1_EMPTY;
                    end else begin
                        n_digits = r_digits + 2'd1;
                    end
                end
                default: begin
                    if ((r_left < 8'd2) && (i_byte <= TYPE_TXT)) begin
                        // unit complete: flush a pending number, take new type
                        if (conv1 && (r_phase inside {PH_T1_NUM, PH_T1_JUNK})) begin
                            cmd.lits[lc] = r_acc[15:8];
                            lc = lc + 2'd1;
                            cmd.lits[lc] = r_acc[7:0];
                            lc = lc + 2'd1;
                        end
                        do_type = 1'b1;
                    end else begin
                        if (!conv1) begin
                            cmd.lits[lc] = i_byte;
                            lc = lc + 2'd1;
                        end
                        if (i_byte == CHAR_COMMA) begin
                            if (conv1) begin
                                cmd.lits[lc] = r_acc[15:8];
                                lc = lc + 2'd1;
                                cmd.lits[lc] = r_acc[7:0];
                                lc = lc + 2'd1;
                            end
                            n_acc = 16'd0;
                            if (r_left != 8'd0) n_left = r_left - 8'd1;
                            n_phase = PH_T1_EMPTY;
                        end else if (is_digit && (r_phase != PH_T1_JUNK)) begin
                            n_acc   = 16'(r_acc * 16'd10 + {12'd0, dig});
                            n_phase = PH_T1_NUM;
                        end else begin
                            n_phase = PH_T1_JUNK;
                        end
                    end
                end
            endcase

            if (do_type) begin
                if (i_byte == TYPE_BIN) begin
                    n_phase      = PH_T0_COUNT;
                    cmd.lits[lc] = conv0 ? TYPE_TXT : TYPE_BIN;
                    lc = lc + 2'd1;
                end else if (i_byte == TYPE_TXT) begin
                    n_phase      = PH_T1_COUNT;
                    n_digits     = 2'd0;
                    n_cnt        = 10'd0;
                    n_stop       = 1'b0;
                    cmd.lits[lc] = conv1 ? TYPE_BIN : TYPE_TXT;
                    lc = lc + 2'd1;
                end else begin
                    n_err   = 1'b1;
                    n_phase = PH_TYPE;
                    cmd.st  = ST_BAD_TYPE;
                end
            end

            if (i_last) begin
                if (n_phase inside {PH_T1_EMPTY, PH_T1_NUM, PH_T1_JUNK}) begin
                    if (conv1 && (n_phase inside {PH_T1_NUM, PH_T1_JUNK})) begin
                        cmd.lits[lc] = n_acc[15:8];
                        lc = lc + 2'd1;
                        cmd.lits[lc] = n_acc[7:0];
                        lc = lc + 2'd1;
                    end
                end else if (n_phase != PH_TYPE) begin
                    if (cmd.st == ST_OK) cmd.st = ST_TRUNC;
                end
                n_phase = PH_TYPE;
                n_err   = 1'b0;
            end
        end
        cmd.lit_cnt = lc;
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.lit_cnt != 2'd0) || cmd.num_en || (cmd.st != ST_OK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_left   <= 8'd0;
            r_cnt    <= 10'd0;
            r_digits <= 2'd0;
            r_hi     <= 8'd0;
            r_acc    <= 16'd0;
            r_err    <= 1'b0;
            r_stop   <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_cnt    <= n_cnt;
            r_digits <= n_digits;
            r_hi     <= n_hi;
            r_acc    <= n_acc;
            r_err    <= n_err;
            r_stop   <= n_stop;
        end
    end

endmodule

// ===== rtl/nuft_queue.sv =====
module nuft_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nuft_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output nuft_pkg::t_cmd    o_cmd,
    output logic              o_valid,
    output logic              o_full
);
    import nuft_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    t_cmd          r_head;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_cmd   = r_head;
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) n_wr = (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
        if (rd_en) n_rd = (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
        if (wr_en && !rd_en)      n_cnt = r_cnt + CW'(1);
        else if (!wr_en && rd_en) n_cnt = r_cnt - CW'(1);
    end

    // Prefetch the next head entry; bypass the write when it lands on that slot
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_cmd;
        r_head <= (wr_en && (r_wr == n_rd)) ? i_cmd : r_mem[n_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/nuft_back.sv =====
module nuft_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nuft_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_pop,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic [7:0]        o_tdata,   // out_byte
    output logic [2:0]        o_tuser,   // [0] out_valid, [2:1] status
    output logic              o_tlast    // out_last
);
    import nuft_pkg::*;

    // working command
    logic                  r_busy, n_busy;
    logic [LIT_N-1:0][7:0] r_lits, n_lits;
    logic [1:0]            r_lcnt, n_lcnt;
    logic                  r_num_en, n_num_en;
    logic [15:0]           r_val, n_val;
    logic [2:0]            r_pos, n_pos;
    logic                  r_comma, n_comma;
    logic [1:0]            r_st, n_st;

    // output register
    logic                  r_ov, n_ov;
    logic [7:0]            r_byte, n_byte;
    logic                  r_bv, n_bv;
    logic                  r_last, n_last;
    logic [1:0]            r_ost, n_ost;

    // after the current element
    logic [LIT_N-1:0][7:0] a_lits;
    logic [1:0]            a_lcnt;
    logic                  a_num_en;
    logic [15:0]           a_val;
    logic [2:0]            a_pos;
    logic                  a_comma;
    logic [7:0]            e_byte;
    logic                  e_valid;
    logic [19:0]           split;
    logic                  fin, adv, pop;

    assign split = dec_step(r_val, r_pos);

    always_comb begin
        a_lits   = r_lits;
        a_lcnt   = r_lcnt;
        a_num_en = r_num_en;
        a_val    = r_val;
        a_pos    = r_pos;
        a_comma  = r_comma;
        e_byte   = 8'd0;
        e_valid  = 1'b1;
        if (r_lcnt != 2'd0) begin
            e_byte = r_lits[0];
            for (int i = 0; i < LIT_N - 1; i++) a_lits[i] = r_lits[i+1];
            a_lits[LIT_N-1] = 8'd0;
            a_lcnt = r_lcnt - 2'd1;
        end else if (r_num_en) begin
            e_byte = CHAR_ZERO + {4'd0, split[19:16]};
            a_val  = split[15:0];
            if (r_pos == 3'd0) a_num_en = 1'b0;
            else               a_pos    = r_pos - 3'd1;
        end else if (r_comma) begin
            e_byte  = CHAR_COMMA;
            a_comma = 1'b0;
        end else begin
            // status with no bytes
            e_valid = 1'b0;
        end
    end

    assign fin = (a_lcnt == 2'd0) && !a_num_en && !a_comma;
    assign adv = r_busy && (!r_ov || i_tready);
    assign pop = i_cmd_valid && (!r_busy || (adv && fin));

    always_comb begin
        n_ov   = r_ov;
        n_byte = r_byte;
        n_bv   = r_bv;
        n_last = r_last;
        n_ost  = r_ost;
        if (adv) begin
            n_ov   = 1'b1;
            n_byte = e_byte;
            n_bv   = e_valid;
            n_last = fin;
            n_ost  = fin ? r_st : ST_OK;
        end else if (i_tready) begin
            n_ov = 1'b0;
        end

        n_busy   = r_busy;
        n_lits   = r_lits;
        n_lcnt   = r_lcnt;
        n_num_en = r_num_en;
        n_val    = r_val;
        n_pos    = r_pos;
        n_comma  = r_comma;
        n_st     = r_st;
        if (pop) begin
            n_busy   = 1'b1;
            n_lits   = i_cmd.lits;
            n_lcnt   = i_cmd.lit_cnt;
            n_num_en = i_cmd.num_en;
            n_val    = i_cmd.num_val;
            n_pos    = i_cmd.num_pos;
            n_comma  = i_cmd.comma;
            n_st     = i_cmd.st;
        end else if (adv) begin
            n_busy   = !fin;
            n_lits   = a_lits;
            n_lcnt   = a_lcnt;
            n_num_en = a_num_en;
            n_val    = a_val;
            n_pos    = a_pos;
            n_comma  = a_comma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lits   <= n_lits;
        r_lcnt   <= n_lcnt;
        r_num_en <= n_num_en;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_comma  <= n_comma;
        r_st     <= n_st;
        r_byte   <= n_byte;
        r_bv     <= n_bv;
        r_last   <= n_last;
        r_ost    <= n_ost;
    end

    assign o_pop    = pop;
    assign o_tvalid = r_ov;
    assign o_tdata  = r_byte;
    assign o_tuser  = {r_ost, r_bv};
    assign o_tlast  = r_last;

endmodule

// ===== rtl/numeric_unit_format_translator_unit.sv =====
// Translates a byte stream of numeric units. A unit starting with type byte 0
// holds a count byte and that many big-endian 16-bit numbers; a unit starting
// with type byte 1 holds three ASCII count digits and comma-separated decimal
// numbers. Register conversion_mode (address 0, reset 1) selects per unit type
// whether the unit is copied or converted: bit 0 turns binary units into text,
// bit 1 turns text units into binary. Decimal numbers are written in full with
// no leading zeros, the count as three digits; binary numbers are big-endian.
// Each input byte is taken by the parser and yields zero to six output bytes;
// the output side writes one transfer per cycle while the sink is ready, so
// the output serializer sets the sustained rate, and a command queue between
// the two lets the parser run ahead by QUEUE_DEPTH input bytes that yield
// output (bytes with nothing to write never enter it).
// The last output byte of an input byte carries tlast and the status
// (unknown type byte, or stream ended inside a unit); when such a byte yields
// no data, a single transfer with out_valid low carries the status. After an
// unknown type byte, input is dropped up to the byte marked tlast.
module numeric_unit_format_translator_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // source stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // in_last

    // translated stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [2:0]  m_axis_tuser,   // [0] out_valid, [2:1] status
    output logic        m_axis_tlast,   // out_last

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nuft_pkg::*;

    localparam logic ADDR_MODE = 1'b0;
    localparam logic [1:0] MODE_RESET = 2'd1;

    logic [1:0] r_mode;
    logic       cfg_wr;
    logic       w_push, w_pop, w_valid, w_full;
    t_cmd       w_cmd_in, w_cmd_out;

    // Register file: a single two-bit mode, written in the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_MODE);
    assign prdata = (paddr[2] == ADDR_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (cfg_wr) begin
            r_mode <= pwdata[1:0];
        end
    end

    // Hold off the source only while the command queue is full
    assign s_axis_tready = !w_full;

    // Front: parse each byte, advance unit state, build its output command
    nuft_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_space (!w_full),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_mode  (r_mode),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    nuft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_valid (w_valid),
        .o_full  (w_full)
    );

    // Back: expand each command into output bytes, one transfer per cycle while the sink is ready
    nuft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (w_valid),
        .o_pop       (w_pop),
        .i_tready    (m_axis_tready),
        .o_tvalid    (m_axis_tvalid),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

    // A command is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into full queue");

    // A status rides only on the final transfer of an input byte
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == ST_OK))
        else $error("status on a non-final transfer");

    // A transfer without data exists only to carry a status
    a_empty_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tlast && (m_axis_tuser[2:1] != ST_OK)))
        else $error("empty transfer without status");

    // Nothing is popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid)
        else $error("pop from empty queue");

endmodule

// ===== dv/tb_numeric_unit_format_translator_unit.sv =====
`timescale 1ns / 1ps

module tb_numeric_unit_format_translator_unit;
    import nuft_pkg::*;

    // conversion_mode settings: bit 0 turns binary units into text,
    // bit 1 turns text units into binary
    localparam logic [1:0] MODE_PASS     = 2'd0;
    localparam logic [1:0] MODE_BIN2TXT  = 2'd1;
    localparam logic [1:0] MODE_TXT2BIN  = 2'd2;
    localparam logic [1:0] MODE_BOTH     = 2'd3;
    localparam logic [2:0] ADDR_CONV_MODE = 3'd0;

    localparam int MAX_BYTES_PER_STEP = 6;
    localparam int RANDOM_BYTES       = 145;
    localparam int CALM_TAIL_BYTES    = 40;
    // parser can run ahead of the output side by a few commands
    localparam int DRAIN_CYCLES       = 40;
    localparam int CYCLE_LIMIT        = 300000;

    // One transfer on the translated stream
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [1:0] status;
    } t_out_beat;

    // Tracks the translator state and the output bytes still owed
    class translation_scoreboard;
        logic [1:0]  mode;
        t_phase      phase;
        logic        kind;
        logic [7:0]  nums_left;
        logic [9:0]  count_val;
        logic [1:0]  digits_seen;
        logic        count_stopped;
        logic [7:0]  held_hi;
        logic [15:0] acc;
        logic        skip_to_last;
        t_out_beat   expected_beats[$];
        t_out_beat   step_beats[$];
        int          mismatches;

        function new();
            mode          = MODE_BIN2TXT;
            phase         = PH_TYPE;
            kind          = 1'b0;
            nums_left     = 8'd0;
            count_val     = 10'd0;
            digits_seen   = 2'd0;
            count_stopped = 1'b0;
            held_hi       = 8'd0;
            acc           = 16'd0;
            skip_to_last  = 1'b0;
            mismatches    = 0;
        endfunction

        function void put(logic [7:0] b);
            t_out_beat x;
            if (step_beats.size() >= MAX_BYTES_PER_STEP) return;
            x.data   = b;
            x.valid  = 1'b1;
            x.last   = 1'b0;
            x.status = ST_OK;
            step_beats.push_back(x);
        endfunction

        // full decimal text, no leading zeros
        function void put_decimal(logic [15:0] v);
            int unsigned div;
            int unsigned d;
            logic        lead;
            lead = 1'b0;
            for (div = 10000; div > 0; div = div / 10) begin
                d = (int'(v) / div) % 10;
                if (d != 0 || lead || div == 1) begin
                    put(CHAR_ZERO + 8'(d));
                    lead = 1'b1;
                end
            end
        endfunction

        function logic [1:0] take_type(logic [7:0] b);
            if (b == TYPE_BIN) begin
                kind  = 1'b0;
                phase = PH_T0_COUNT;
                put(mode[0] ? TYPE_TXT : TYPE_BIN);
                return ST_OK;
            end
            if (b == TYPE_TXT) begin
                kind          = 1'b1;
                phase         = PH_T1_COUNT;
                digits_seen   = 2'd0;
                count_val     = 10'd0;
                count_stopped = 1'b0;
                put(mode[1] ? TYPE_BIN : TYPE_TXT);
                return ST_OK;
            end
            skip_to_last = 1'b1;
            phase        = PH_TYPE;
            return ST_BAD_TYPE;
        endfunction

        // a pending number goes out only if a byte followed the last comma
        function void close_text_unit();
            if (mode[1] && (phase == PH_T1_NUM || phase == PH_T1_JUNK)) begin
                put(acc[15:8]);
                put(acc[7:0]);
            end
            phase = PH_TYPE;
        endfunction

        function void note_source_byte(logic [7:0] b, logic lst);
            logic [1:0] st;
            logic       is_dig;
            t_out_beat  x;
            st = ST_OK;
            step_beats.delete();
            is_dig = (b >= CHAR_ZERO && b <= CHAR_NINE);
            if (skip_to_last) begin
                if (lst) begin
                    skip_to_last = 1'b0;
                    phase        = PH_TYPE;
                end
                return;
            end
            case (phase)
                PH_TYPE: st = take_type(b);
                PH_T0_COUNT: begin
                    nums_left = b;
                    if (mode[0]) begin
                        put(CHAR_ZERO + b / 8'd100);
                        put(CHAR_ZERO + (b / 8'd10) % 8'd10);
                        put(CHAR_ZERO + b % 8'd10);
                    end else begin
                        put(b);
                    end
                    if (b != 8'd0) phase = PH_T0_HI;
                    else phase = PH_TYPE;
                end
                PH_T0_HI: begin
                    held_hi = b;
                    phase   = PH_T0_LO;
                end
                PH_T0_LO: begin
                    if (mode[0]) begin
                        put_decimal({held_hi, b});
                        if (nums_left > 8'd1) put(CHAR_COMMA);
                    end else begin
                        put(held_hi);
                        put(b);
                    end
                    if (nums_left != 8'd0) nums_left--;
                    if (nums_left != 8'd0) phase = PH_T0_HI;
                    else phase = PH_TYPE;
                end
                PH_T1_COUNT: begin
                    if (!mode[1]) put(b);
                    if (is_dig && !count_stopped)
                        count_val = 10'(int'(count_val) * 10 + int'(b) - int'(CHAR_ZERO));
                    else
                        count_stopped = 1'b1;
                    if (digits_seen >= 2'd2) begin
                        nums_left = count_val[7:0];
                        if (mode[1]) put(nums_left);
                        digits_seen = 2'd0;
                        acc         = 16'd0;
                        phase       = PH_T1_EMPTY;
                    end else begin
                        digits_seen++;
                    end
                end
                default: begin
                    if (nums_left < 8'd2 && b <= TYPE_TXT) begin
                        close_text_unit();
                        st = take_type(b);
                    end else begin
                        if (!mode[1]) put(b);
                        if (b == CHAR_COMMA) begin
                            if (mode[1]) begin
                                put(acc[15:8]);
                                put(acc[7:0]);
                            end
                            acc = 16'd0;
                            if (nums_left != 8'd0) nums_left--;
                            phase = PH_T1_EMPTY;
                        end else if (is_dig && phase != PH_T1_JUNK) begin
                            acc   = 16'(int'(acc) * 10 + int'(b) - int'(CHAR_ZERO));
                            phase = PH_T1_NUM;
                        end else begin
                            phase = PH_T1_JUNK;
                        end
                    end
                end
            endcase

            if (lst) begin
                if (phase >= PH_T1_EMPTY) close_text_unit();
                else if (phase != PH_TYPE && st == ST_OK) st = ST_TRUNC;
                phase        = PH_TYPE;
                skip_to_last = 1'b0;
            end

            // a status with no data rides on a transfer with out_valid low
            if (st != ST_OK && step_beats.size() == 0) begin
                x.data   = 8'h00;
                x.valid  = 1'b0;
                x.last   = 1'b0;
                x.status = ST_OK;
                step_beats.push_back(x);
            end
            if (step_beats.size() != 0) begin
                x        = step_beats[step_beats.size() - 1];
                x.last   = 1'b1;
                x.status = st;
                step_beats[step_beats.size() - 1] = x;
            end
            foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_output_byte(logic [7:0] data, logic [2:0] user, logic last);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                $display("%0t: output transfer expected none, actual data=%0h user=%0h last=%0b",
                         $time, data, user, last);
                return;
            end
            want = expected_beats.pop_front();
            compare_field("out_byte", want.data, data);
            compare_field("out_valid", 8'(want.valid), 8'(user[0]));
            compare_field("out_last", 8'(want.last), 8'(last));
            compare_field("status", 8'(want.status), 8'(user[2:1]));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [7:0]  m_axis_tdata;     // out_byte
    logic [2:0]  m_axis_tuser;     // [0] out_valid, [2:1] status
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    translation_scoreboard sb;

    // idling controls: gaps_on allows bursts at all; odds are percent per source byte, per sink cycle
    logic        gaps_on = 1'b1;
    int          src_gap_odds = 0;
    int          sink_stall_odds = 0;
    int          sink_stall_left = 0;
    int          cycle_count = 0;
    logic [7:0]  stream_q[$];

    numeric_unit_format_translator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or owes transfers forever
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Monitor: both sides are sampled at the edge, before any drive of this edge lands.
    // Note the source transfer first so a same-edge result finds its expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_source_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Sink back-pressure: drop tready for random bursts
    always @(posedge i_clk) begin
        if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_axis_tready   <= (sink_stall_left == 1);
        end else if (gaps_on && sink_stall_odds != 0 &&
                     $urandom_range(1, 100) <= sink_stall_odds) begin
            sink_stall_left <= $urandom_range(1, 19);
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one byte, maybe after a gap, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (gaps_on && src_gap_odds != 0 && $urandom_range(1, 100) <= src_gap_odds) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Send the built stream, tlast on its final byte
    task automatic send_stream();
        foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    // Drop valid, wait for every owed transfer, then let the command queue drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Two-phase register write; the register takes it on the access edge
    task automatic write_mode(input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CONV_MODE;
        pwdata  <= {30'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.mode = value;
    endtask

    // Binary unit: count byte then big-endian numbers, often with a zero high byte
    function automatic void add_bin_unit(int cnt, int nums);
        stream_q.push_back(TYPE_BIN);
        stream_q.push_back(8'(cnt));
        repeat (nums) begin
            stream_q.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom));
            stream_q.push_back(8'($urandom));
        end
    endfunction

    // Decimal field: 0 to 5 digits (5 digits may wrap past 65535), sometimes trailing junk
    function automatic void add_text_number();
        int ndig;
        ndig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        repeat (ndig) stream_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) stream_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
    endfunction

    // Text unit: three count digits then comma-separated numbers
    function automatic void add_text_unit(int cnt);
        stream_q.push_back(TYPE_TXT);
        if ($urandom_range(0, 9) == 0) begin
            // broken count field: stops at the first non-digit
            repeat (3) stream_q.push_back(8'($urandom_range(8'h20, 8'h7f)));
        end else begin
            stream_q.push_back(CHAR_ZERO + 8'(cnt / 100));
            stream_q.push_back(CHAR_ZERO + 8'((cnt / 10) % 10));
            stream_q.push_back(CHAR_ZERO + 8'(cnt % 10));
        end
        for (int i = 0; i < cnt; i++) begin
            add_text_number();
            if (i < cnt - 1) stream_q.push_back(CHAR_COMMA);
            if ($urandom_range(0, 11) == 0) stream_q.push_back(CHAR_COMMA);
        end
    endfunction

    // Mostly well-formed streams of 1 to 3 units; the rest is noise,
    // unknown type bytes, oversized counts and streams cut short
    function automatic void build_stream();
        int  pick;
        int  nunits;
        int  keep;
        logic done;
        stream_q.delete();
        done = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(2, 8)) stream_q.push_back(8'($urandom));
            return;
        end
        nunits = $urandom_range(1, 3);
        repeat (nunits) begin
            if (!done) begin
                pick = $urandom_range(0, 99);
                if (pick < 42) begin
                    pick = $urandom_range(0, 4);
                    add_bin_unit(pick, pick);
                end else if (pick < 84) begin
                    add_text_unit($urandom_range(0, 4));
                end else if (pick < 92) begin
                    stream_q.push_back(8'($urandom_range(2, 255)));
                    repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom));
                    done = 1'b1;
                end else begin
                    add_bin_unit($urandom_range(5, 255), $urandom_range(0, 2));
                    done = 1'b1;
                end
            end
        end
        if ($urandom_range(0, 4) == 0 && stream_q.size() > 1) begin
            keep = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > keep) void'(stream_q.pop_back());
        end
    endfunction

    initial begin
        int sent;
        int stream_no;
        sb = new();

        // hold reset, then release it on an edge
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset mode converts binary units; largest number and 7,
        // comma only between numbers
        stream_q = '{TYPE_BIN, 8'd2, 8'hFF, 8'hFF, 8'h00, 8'h07};
        send_stream();
        // unknown type byte, then everything up to tlast dropped
        stream_q = '{8'h05, 8'hAA, 8'h00};
        send_stream();
        // binary unit cut short by tlast
        stream_q = '{TYPE_BIN, 8'd3, 8'h12};
        send_stream();
        // convert both: a 5-digit number that wraps, then a number ended by junk
        // and closed by tlast
        wait_idle();
        write_mode(MODE_BOTH);
        stream_q = '{TYPE_TXT, "0", "0", "2", "7", "0", "0", "0", "0", CHAR_COMMA,
                     "4", "x", "2"};
        send_stream();

        // Random streams; sweep every mode first, then pick at random
        sent      = 0;
        stream_no = 0;
        while (sent < RANDOM_BYTES) begin
            if (stream_no % 3 == 0) begin
                wait_idle();
                if (stream_no < 12) write_mode(2'(stream_no / 3));
                else write_mode(2'($urandom_range(MODE_PASS, MODE_BOTH)));
            end
            // calm tail: no idling on either side near the end
            gaps_on         = (sent < RANDOM_BYTES - CALM_TAIL_BYTES);
            src_gap_odds    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            sink_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            build_stream();
            send_stream();
            sent += stream_q.size();
            stream_no++;
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
